[design/mqttd_pkg.sv]
package mqttd_pkg;

  // Byte roles reported on tuser
  localparam logic [3:0] ROLE_HEADER    = 4'd0;
  localparam logic [3:0] ROLE_LEN_DIGIT = 4'd1;
  localparam logic [3:0] ROLE_TOPIC_LEN = 4'd2;
  localparam logic [3:0] ROLE_TOPIC     = 4'd3;
  localparam logic [3:0] ROLE_PKT_ID    = 4'd4;
  localparam logic [3:0] ROLE_PAYLOAD   = 4'd5;
  localparam logic [3:0] ROLE_ACK_FLAGS = 4'd6;
  localparam logic [3:0] ROLE_RET_CODE  = 4'd7;
  localparam logic [3:0] ROLE_OTHER     = 4'd8;

  // Error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_RESERVED     = 3'd1;
  localparam logic [2:0] ERR_LEN_DIGITS   = 3'd2;
  localparam logic [2:0] ERR_PUBACK_LEN   = 3'd3;
  localparam logic [2:0] ERR_PUBLISH_LEN  = 3'd4;
  localparam logic [2:0] ERR_CONN_REFUSED = 3'd5;

  // Control packet types
  localparam logic [3:0] TYPE_RESERVED = 4'd0;
  localparam logic [3:0] TYPE_CONNACK  = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_PUBACK   = 4'd4;

  // Header masks and length digit fields
  localparam logic [7:0] HDR_TYPE_MASK = 8'hF0;
  localparam logic [7:0] HDR_QOS_MASK  = 8'h06;
  localparam logic [7:0] DIGIT_MASK    = 8'd127;
  localparam logic [7:0] DIGIT_CONT    = 8'd128;

  // Width of the packed output tdata
  localparam int unsigned OUT_TDATA_W = 64;

endpackage

[design/mqtt_packet_deframer_core.sv]
// MQTT fixed header deframer.
// Slave stream (s_axis_*): one received byte of the MQTT stream per beat.
// Master stream (m_axis_*): one result beat per input byte; the byte passes
// through with its role on tuser, packet type, QoS, decoded remaining length,
// packet id and error code in tdata, and tlast set on the last byte of a packet.
// A result shows on m_axis_tvalid in the cycle after its byte is taken.
// Throughput: one byte per cycle while results are taken; the parse step is a
// single phase update between the input handshake and the result register.
// The input is taken whenever the result register is empty or is being drained
// in the same cycle, so a stalled receiver holds the result and stops the
// input only while the result stays untaken.
// Reset clears the parser to wait for a header byte and empties the result
// register; the output stays invalid until the first byte arrives.
// Bad packets are flagged on the byte that shows the fault and the rest of
// their body is passed as other body until the length runs out.
module mqtt_packet_deframer_core #(
  parameter int unsigned MAX_LENGTH_DIGITS = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // rx_byte[7:0]
  input  logic [7:0]                              s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // data_byte[7:0], packet_type[11:8], qos_level[13:12],
  // remaining_length[41:14], message_id[57:42], error_code[60:58], zero[63:61]
  output logic [mqttd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // byte_role[3:0]
  output logic [3:0]                              m_axis_tuser,
  // end_of_packet
  output logic                                    m_axis_tlast
);
  import mqttd_pkg::*;

  // Parser phases
  localparam logic [3:0] PH_HEADER    = 4'd0;
  localparam logic [3:0] PH_LENGTH    = 4'd1;
  localparam logic [3:0] PH_TLEN_HI   = 4'd2;
  localparam logic [3:0] PH_TLEN_LO   = 4'd3;
  localparam logic [3:0] PH_TOPIC     = 4'd4;
  localparam logic [3:0] PH_ID_HI     = 4'd5;
  localparam logic [3:0] PH_ID_LO     = 4'd6;
  localparam logic [3:0] PH_PAYLOAD   = 4'd7;
  localparam logic [3:0] PH_ACK_FLAGS = 4'd8;
  localparam logic [3:0] PH_RET_CODE  = 4'd9;
  localparam logic [3:0] PH_OTHER     = 4'd10;
  localparam logic [3:0] PH_SKIP      = 4'd11;

  localparam logic [2:0] MaxDigits = 3'(MAX_LENGTH_DIGITS);

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [1:0]  qos_q, qos_d;
  logic [27:0] len_acc_q, len_acc_d;
  logic [2:0]  digit_cnt_q, digit_cnt_d;
  logic [27:0] bytes_left_q, bytes_left_d;
  logic [15:0] topic_left_q, topic_left_d;
  logic [15:0] id_acc_q, id_acc_d;

  logic        out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [3:0]  out_role_q;
  logic        out_last_q;

  logic        in_beat;
  logic [3:0]  role;
  logic [2:0]  err;
  logic        eop;
  logic [27:0] digit_shifted;
  logic [16:0] need;
  logic        last_body;
  logic        bad;

  // Accept while the result register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Place the current digit at its base-128 position
  always_comb begin
    case (digit_cnt_q[1:0])
      2'd0:    digit_shifted = {21'd0, s_axis_tdata[6:0]};
      2'd1:    digit_shifted = {14'd0, s_axis_tdata[6:0], 7'd0};
      2'd2:    digit_shifted = {7'd0, s_axis_tdata[6:0], 14'd0};
      default: digit_shifted = {s_axis_tdata[6:0], 21'd0};
    endcase
  end

  // One parse step for the incoming byte
  always_comb begin
    phase_d      = phase_q;
    type_d       = type_q;
    qos_d        = qos_q;
    len_acc_d    = len_acc_q;
    digit_cnt_d  = digit_cnt_q;
    bytes_left_d = bytes_left_q;
    topic_left_d = topic_left_q;
    id_acc_d     = id_acc_q;
    role         = ROLE_OTHER;
    err          = ERR_NONE;
    eop          = 1'b0;
    need         = '0;
    bad          = 1'b0;
    last_body    = (bytes_left_q <= 28'd1);

    if (phase_q == PH_HEADER || phase_q > PH_SKIP) begin
      type_d       = 4'((s_axis_tdata & HDR_TYPE_MASK) >> 4);
      qos_d        = 2'((s_axis_tdata & HDR_QOS_MASK) >> 1);
      len_acc_d    = '0;
      digit_cnt_d  = '0;
      bytes_left_d = '0;
      topic_left_d = '0;
      id_acc_d     = '0;
      role         = ROLE_HEADER;
      if (type_d == TYPE_RESERVED) begin
        err = ERR_RESERVED;
      end
      phase_d = PH_LENGTH;
    end else if (phase_q == PH_LENGTH) begin
      role = ROLE_LEN_DIGIT;
      if (digit_cnt_q < 3'd4) begin
        len_acc_d = len_acc_q | digit_shifted;
      end
      digit_cnt_d = digit_cnt_q + 3'd1;
      if ((s_axis_tdata & DIGIT_CONT) != 8'd0) begin
        if (digit_cnt_d >= MaxDigits) begin
          err     = ERR_LEN_DIGITS;
          eop     = 1'b1;
          phase_d = PH_HEADER;
        end
      end else begin
        bytes_left_d = len_acc_d;
        if (type_q == TYPE_RESERVED) begin
          bad = 1'b1;
        end else if (type_q == TYPE_PUBACK && len_acc_d != 28'd2) begin
          err = ERR_PUBACK_LEN;
          bad = 1'b1;
        end else if (type_q == TYPE_PUBLISH && len_acc_d < 28'd2) begin
          err = ERR_PUBLISH_LEN;
          bad = 1'b1;
        end
        if (len_acc_d == 28'd0) begin
          eop     = 1'b1;
          phase_d = PH_HEADER;
        end else if (bad) begin
          phase_d = PH_SKIP;
        end else if (type_q == TYPE_PUBLISH) begin
          phase_d = PH_TLEN_HI;
        end else if (type_q == TYPE_CONNACK) begin
          phase_d = PH_ACK_FLAGS;
        end else begin
          phase_d = PH_OTHER;
        end
      end
    end else begin
      // Body byte: count down the remaining length
      bytes_left_d = last_body ? 28'd0 : bytes_left_q - 28'd1;
      unique case (phase_q)
        PH_TLEN_HI: begin
          role         = ROLE_TOPIC_LEN;
          topic_left_d = {s_axis_tdata, 8'd0};
          phase_d      = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          role         = ROLE_TOPIC_LEN;
          topic_left_d = topic_left_q | {8'd0, s_axis_tdata};
          need         = {1'b0, topic_left_d} + ((qos_q != 2'd0) ? 17'd2 : 17'd0);
          if ({11'd0, need} > bytes_left_d) begin
            err     = ERR_PUBLISH_LEN;
            phase_d = PH_SKIP;
          end else if (topic_left_d != 16'd0) begin
            phase_d = PH_TOPIC;
          end else begin
            phase_d = (qos_q != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
          end
        end
        PH_TOPIC: begin
          role = ROLE_TOPIC;
          if (topic_left_q != 16'd0) begin
            topic_left_d = topic_left_q - 16'd1;
          end
          if (topic_left_d == 16'd0) begin
            phase_d = (qos_q != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
          end
        end
        PH_ID_HI: begin
          role     = ROLE_PKT_ID;
          id_acc_d = {s_axis_tdata, 8'd0};
          phase_d  = PH_ID_LO;
        end
        PH_ID_LO: begin
          role     = ROLE_PKT_ID;
          id_acc_d = id_acc_q | {8'd0, s_axis_tdata};
          phase_d  = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          role = ROLE_PAYLOAD;
        end
        PH_ACK_FLAGS: begin
          role    = ROLE_ACK_FLAGS;
          phase_d = PH_RET_CODE;
        end
        PH_RET_CODE: begin
          role = ROLE_RET_CODE;
          if (s_axis_tdata != 8'd0) begin
            err = ERR_CONN_REFUSED;
          end
          phase_d = PH_OTHER;
        end
        default: begin
          role = ROLE_OTHER;
        end
      endcase
      if (last_body) begin
        eop     = 1'b1;
        phase_d = PH_HEADER;
      end
    end
  end

  // Advance the parser state on each input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      type_q       <= '0;
      qos_q        <= '0;
      len_acc_q    <= '0;
      digit_cnt_q  <= '0;
      bytes_left_q <= '0;
      topic_left_q <= '0;
      id_acc_q     <= '0;
    end else if (in_beat) begin
      phase_q      <= phase_d;
      type_q       <= type_d;
      qos_q        <= qos_d;
      len_acc_q    <= len_acc_d;
      digit_cnt_q  <= digit_cnt_d;
      bytes_left_q <= bytes_left_d;
      topic_left_q <= topic_left_d;
      id_acc_q     <= id_acc_d;
    end
  end

  // Hold the result valid until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload on each input beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= {3'd0, err, id_acc_d, len_acc_d, qos_d, type_d, s_axis_tdata};
      out_role_q <= role;
      out_last_q <= eop;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_role_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[design/mqttd_checker.sv]
module mqttd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mqttd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [3:0]                        m_axis_tuser,
  input logic                              m_axis_tlast
);
  import mqttd_pkg::*;

  logic out_beat;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Hold a stalled result beat unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("result beat changed while stalled");

  // A header beat starts with cleared length and id
  a_header_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && m_axis_tuser == ROLE_HEADER) |->
      (m_axis_tdata[41:14] == 28'd0 && m_axis_tdata[57:42] == 16'd0 && !m_axis_tlast))
    else $error("header beat carries stale length or id");

  // Flag a reserved type exactly on its header beat
  a_header_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && m_axis_tuser == ROLE_HEADER) |->
      ((m_axis_tdata[60:58] == ERR_RESERVED) == (m_axis_tdata[11:8] == TYPE_RESERVED)))
    else $error("reserved type flag mismatch on header beat");

  // A length overflow ends the packet on a length digit
  a_len_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && m_axis_tdata[60:58] == ERR_LEN_DIGITS) |->
      (m_axis_tlast && m_axis_tuser == ROLE_LEN_DIGIT))
    else $error("length overflow not closing the packet");

endmodule

bind mqtt_packet_deframer_core mqttd_checker u_mqttd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mqttd_pkg::*;

  localparam int unsigned LEN_DIGIT_LIMIT = 4;
  localparam int unsigned NUM_DIRECTED    = 25;
  localparam int unsigned RANDOM_BYTES    = 1600;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned HOLD_OFF_AT     = 600;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // Parser position inside a packet
  typedef enum logic [3:0] {
    ST_HEADER, ST_LENGTH, ST_TOPIC_LEN_HI, ST_TOPIC_LEN_LO, ST_TOPIC, ST_ID_HI,
    ST_ID_LO, ST_PAYLOAD, ST_ACK_FLAGS, ST_RET_CODE, ST_OTHER, ST_SKIP
  } parse_st_e;

  // One tagged output byte
  typedef struct {
    logic [7:0]  data;
    logic [3:0]  role;
    logic [3:0]  ptype;
    logic [1:0]  qos;
    logic [27:0] rem_len;
    logic [15:0] pkt_id;
    logic        last;
    logic [2:0]  err;
  } beat_t;

  // Directed byte; role, error and end flag are typed in where pinned
  typedef struct packed {
    logic [7:0] rx;
    logic       pinned;
    logic [3:0] role;
    logic [2:0] err;
    logic       eop;
  } stim_row_t;

  typedef logic [7:0] byte_q_t [$];

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Predictor state
  parse_st_e   parse_st   = ST_HEADER;
  logic [3:0]  hdr_type   = '0;
  logic [1:0]  hdr_qos    = '0;
  logic [27:0] len_acc    = '0;
  logic [2:0]  len_digits = '0;
  logic [27:0] body_left  = '0;
  logic [15:0] topic_left = '0;
  logic [15:0] id_acc     = '0;

  beat_t       pending_beats [$];
  int unsigned fail_count  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // reserved type, zero length: flagged on the header, ends on its length byte
    '{8'h00, 1'b1, ROLE_HEADER,    ERR_RESERVED,     1'b0},
    '{8'h00, 1'b1, ROLE_LEN_DIGIT, ERR_NONE,         1'b1},
    // PUBACK of length 3: flagged on the length, body skipped
    '{8'h40, 1'b1, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h03, 1'b1, ROLE_LEN_DIGIT, ERR_PUBACK_LEN,   1'b0},
    '{8'hFF, 1'b1, ROLE_OTHER,     ERR_NONE,         1'b0},
    '{8'h00, 1'b1, ROLE_OTHER,     ERR_NONE,         1'b0},
    '{8'hAA, 1'b1, ROLE_OTHER,     ERR_NONE,         1'b1},
    // all-ones header, then four continued digits: too many digits ends the packet
    '{8'hFF, 1'b1, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'hFF, 1'b1, ROLE_LEN_DIGIT, ERR_NONE,         1'b0},
    '{8'hFF, 1'b1, ROLE_LEN_DIGIT, ERR_NONE,         1'b0},
    '{8'hFF, 1'b1, ROLE_LEN_DIGIT, ERR_NONE,         1'b0},
    '{8'hFF, 1'b1, ROLE_LEN_DIGIT, ERR_LEN_DIGITS,   1'b1},
    // CONNACK refused
    '{8'h20, 1'b1, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h02, 1'b1, ROLE_LEN_DIGIT, ERR_NONE,         1'b0},
    '{8'h00, 1'b1, ROLE_ACK_FLAGS, ERR_NONE,         1'b0},
    '{8'h05, 1'b1, ROLE_RET_CODE,  ERR_CONN_REFUSED, 1'b1},
    // PUBLISH QoS 1, length 6 over two digits, one topic byte, id, one payload byte
    '{8'h3B, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h86, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h00, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h00, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h01, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h61, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h12, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'h34, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0},
    '{8'hFE, 1'b0, ROLE_HEADER,    ERR_NONE,         1'b0}
  };

  mqtt_packet_deframer_core #(
    .MAX_LENGTH_DIGITS(LEN_DIGIT_LIMIT)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Deframe one byte: advance the parser and return its tagged beat
  function automatic beat_t deframe_byte(input logic [7:0] b);
    beat_t       r;
    logic        bad;
    logic        body_end;
    logic [16:0] need;
    r.data = b;
    r.role = ROLE_OTHER;
    r.err  = ERR_NONE;
    r.last = 1'b0;
    if (parse_st == ST_HEADER) begin
      hdr_type   = b[7:4];
      hdr_qos    = b[2:1];
      len_acc    = '0;
      len_digits = '0;
      body_left  = '0;
      topic_left = '0;
      id_acc     = '0;
      r.role     = ROLE_HEADER;
      if (hdr_type == TYPE_RESERVED) r.err = ERR_RESERVED;
      parse_st = ST_LENGTH;
    end else if (parse_st == ST_LENGTH) begin
      r.role = ROLE_LEN_DIGIT;
      if (len_digits < 4) len_acc = len_acc | (28'(b[6:0]) << (7 * len_digits));
      len_digits = len_digits + 3'd1;
      if (b[7]) begin
        if (len_digits >= LEN_DIGIT_LIMIT) begin
          r.err    = ERR_LEN_DIGITS;
          r.last   = 1'b1;
          parse_st = ST_HEADER;
        end
      end else begin
        bad       = 1'b0;
        body_left = len_acc;
        if (hdr_type == TYPE_RESERVED) begin
          bad = 1'b1;
        end else if (hdr_type == TYPE_PUBACK && len_acc != 28'd2) begin
          r.err = ERR_PUBACK_LEN;
          bad   = 1'b1;
        end else if (hdr_type == TYPE_PUBLISH && len_acc < 28'd2) begin
          r.err = ERR_PUBLISH_LEN;
          bad   = 1'b1;
        end
        if (body_left == '0) begin
          r.last   = 1'b1;
          parse_st = ST_HEADER;
        end else if (bad) begin
          parse_st = ST_SKIP;
        end else if (hdr_type == TYPE_PUBLISH) begin
          parse_st = ST_TOPIC_LEN_HI;
        end else if (hdr_type == TYPE_CONNACK) begin
          parse_st = ST_ACK_FLAGS;
        end else begin
          parse_st = ST_OTHER;
        end
      end
    end else begin
      body_end  = body_left <= 28'd1;
      body_left = body_end ? '0 : body_left - 28'd1;
      case (parse_st)
        ST_TOPIC_LEN_HI: begin
          r.role     = ROLE_TOPIC_LEN;
          topic_left = {b, 8'h00};
          parse_st   = ST_TOPIC_LEN_LO;
        end
        ST_TOPIC_LEN_LO: begin
          r.role          = ROLE_TOPIC_LEN;
          topic_left[7:0] = b;
          need            = 17'(topic_left) + ((hdr_qos != 2'd0) ? 17'd2 : 17'd0);
          if (28'(need) > body_left) begin
            r.err    = ERR_PUBLISH_LEN;
            parse_st = ST_SKIP;
          end else if (topic_left != '0) begin
            parse_st = ST_TOPIC;
          end else begin
            parse_st = (hdr_qos != 2'd0) ? ST_ID_HI : ST_PAYLOAD;
          end
        end
        ST_TOPIC: begin
          r.role = ROLE_TOPIC;
          if (topic_left != '0) topic_left = topic_left - 16'd1;
          if (topic_left == '0) parse_st = (hdr_qos != 2'd0) ? ST_ID_HI : ST_PAYLOAD;
        end
        ST_ID_HI: begin
          r.role   = ROLE_PKT_ID;
          id_acc   = {b, 8'h00};
          parse_st = ST_ID_LO;
        end
        ST_ID_LO: begin
          r.role      = ROLE_PKT_ID;
          id_acc[7:0] = b;
          parse_st    = ST_PAYLOAD;
        end
        ST_PAYLOAD: r.role = ROLE_PAYLOAD;
        ST_ACK_FLAGS: begin
          r.role   = ROLE_ACK_FLAGS;
          parse_st = ST_RET_CODE;
        end
        ST_RET_CODE: begin
          r.role = ROLE_RET_CODE;
          if (b != 8'h00) r.err = ERR_CONN_REFUSED;
          parse_st = ST_OTHER;
        end
        default: r.role = ROLE_OTHER;
      endcase
      if (body_end) begin
        r.last   = 1'b1;
        parse_st = ST_HEADER;
      end
    end
    r.ptype   = hdr_type;
    r.qos     = hdr_qos;
    r.rem_len = len_acc;
    r.pkt_id  = id_acc;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one byte after a random gap; predict its beat once it is taken
  task automatic push_byte(input logic [7:0] b, input logic pinned = 1'b0,
                           input logic [3:0] role = ROLE_HEADER,
                           input logic [2:0] err = ERR_NONE, input logic eop = 1'b0);
    int unsigned gap;
    beat_t       want;
    gap = ((bytes_sent / 97) % 5 == 2) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    want = deframe_byte(b);
    if (pinned) begin
      want.role = role;
      want.err  = err;
      want.last = eop;
    end
    pending_beats.push_back(want);
    bytes_sent++;
  endtask

  // Remaining length, sometimes padded with continued zero digits
  task automatic send_length(input int unsigned len);
    int unsigned nd;
    nd = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    for (int unsigned i = 0; i < nd; i++)
      push_byte({i < nd - 1, 7'(len >> (7 * i))});
  endtask

  // Header, length and body; bytes past the given body are random
  task automatic send_packet(input logic [7:0] hdr, input byte_q_t body,
                             input int unsigned len);
    push_byte(hdr);
    send_length(len);
    for (int unsigned i = 0; i < len; i++)
      push_byte((i < body.size()) ? body[i] : 8'($urandom));
  endtask

  // Keep any length picked up by noise small
  function automatic logic [7:0] filler_byte();
    return (parse_st == ST_LENGTH) ? 8'($urandom_range(0, 15)) : 8'($urandom);
  endfunction

  task automatic send_publish();
    logic [1:0]  qos;
    int unsigned tlen;
    int unsigned len;
    byte_q_t     body;
    qos  = 2'($urandom_range(0, 3));
    tlen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
    body.push_back(8'(tlen >> 8));
    body.push_back(8'(tlen));
    repeat (tlen) body.push_back(8'($urandom));
    if (qos != 2'd0) repeat (2) body.push_back(8'($urandom));
    repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
    len = body.size();
    // break one in four: declared length short, or topic length far too big
    case ($urandom_range(0, 7))
      0: len = $urandom_range(0, len - 1);
      1: body[0] = 8'($urandom_range(1, 255));
      default: ;
    endcase
    send_packet({TYPE_PUBLISH, 1'($urandom), qos, 1'($urandom)}, body, len);
  endtask

  task automatic send_random_packet();
    int unsigned kind;
    byte_q_t     body;
    kind = $urandom_range(0, 15);
    if (kind <= 5) begin
      send_publish();
    end else if (kind <= 7) begin
      send_packet({TYPE_PUBACK, 4'($urandom)}, body,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 2);
    end else if (kind <= 9) begin
      body.push_back(8'($urandom));
      body.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
      send_packet({TYPE_CONNACK, 4'($urandom)}, body,
                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 2);
    end else if (kind == 10) begin
      send_packet({TYPE_RESERVED, 4'($urandom)}, body, $urandom_range(0, 4));
    end else if (kind <= 12) begin
      send_packet(8'($urandom_range(16, 255)), body, $urandom_range(0, 6));
    end else if (kind == 13) begin
      // every digit continued: runs into the digit limit
      push_byte(8'($urandom));
      repeat (LEN_DIGIT_LIMIT) push_byte(8'($urandom) | DIGIT_CONT);
    end else begin
      repeat ($urandom_range(1, 6)) push_byte(filler_byte());
    end
    // finish whatever the noise started
    while (parse_st != ST_HEADER) push_byte(filler_byte());
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin : check_beats
    beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with no byte pending: tdata %0h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        check_field("data_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
        check_field("packet_type", 32'(want.ptype), 32'(m_axis_tdata[11:8]));
        check_field("qos_level", 32'(want.qos), 32'(m_axis_tdata[13:12]));
        check_field("remaining_length", 32'(want.rem_len), 32'(m_axis_tdata[41:14]));
        check_field("message_id", 32'(want.pkt_id), 32'(m_axis_tdata[57:42]));
        check_field("error_code", 32'(want.err), 32'(m_axis_tdata[60:58]));
        check_field("tdata_pad", 32'd0, 32'(m_axis_tdata[63:61]));
        check_field("byte_role", 32'(want.role), 32'(m_axis_tuser));
        check_field("end_of_packet", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, calm stretches and one long hold-off
  initial begin : drain_results
    int unsigned taken;
    int unsigned gap;
    taken         = 0;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      else gap = ((taken / 89) % 5 == 3) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bytes
    foreach (directed_rows[i])
      push_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].role,
                directed_rows[i].err, directed_rows[i].eop);

    // random packets, mostly well formed
    while (bytes_sent < NUM_DIRECTED + RANDOM_BYTES) send_random_packet();
    s_axis_tvalid <= 1'b0;

    // wait for the last results, then let the pipeline settle
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[mqtt_packet_deframer_core.f]
design/mqttd_pkg.sv
design/mqtt_packet_deframer_core.sv
design/mqttd_checker.sv
tb/sv/testbench.sv
